[hdl/cotangent_bending_coefficients_top_assert.svh]
// Assertion macros for the cotangent bending coefficient top level.
`ifndef COTANGENT_BENDING_COEFFICIENTS_TOP_ASSERT_SVH
`define COTANGENT_BENDING_COEFFICIENTS_TOP_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define CBC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("cbc assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define CBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbc assertion failed");

`endif

[hdl/cbc_pkg.sv]
// Types, widths and constants for the cotangent bending coefficient block.
package cbc_pkg;

  localparam int PT_W          = 24;          // input coordinate width
  localparam int E_W           = PT_W + 1;    // edge component width
  localparam int PROD_W        = 2 * E_W;     // product of a pair of edge components
  localparam int DOT_W         = PROD_W;      // |dot| < 2^50
  localparam int CM_W          = PROD_W;      // |cross component| <= 2^49
  localparam int HALF_W        = CM_W / 2;    // split for squaring
  localparam int SQ_W          = 2 * CM_W;    // sum of squared cross components
  localparam int R_W           = SQ_W / 2;    // square root width
  localparam int COT_W         = 31;          // cotangent magnitude width
  localparam int OUT_W         = 32;          // coefficient width
  localparam int FRAC_BITS_DEF = 16;
  localparam int FRONT_LAT     = 5;           // product/square stages in a pair

  localparam logic [COT_W-1:0] COT_MAX = '1;

  typedef struct packed {
    logic signed [E_W-1:0] x;
    logic signed [E_W-1:0] y;
    logic signed [E_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [PT_W-1:0] p0_x;
    logic signed [PT_W-1:0] p0_y;
    logic signed [PT_W-1:0] p0_z;
    logic signed [PT_W-1:0] p1_x;
    logic signed [PT_W-1:0] p1_y;
    logic signed [PT_W-1:0] p1_z;
    logic signed [PT_W-1:0] p2_x;
    logic signed [PT_W-1:0] p2_y;
    logic signed [PT_W-1:0] p2_z;
    logic signed [PT_W-1:0] p3_x;
    logic signed [PT_W-1:0] p3_y;
    logic signed [PT_W-1:0] p3_z;
  } cbc_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] coef_a;
    logic signed [OUT_W-1:0] coef_b;
    logic signed [OUT_W-1:0] coef_c;
    logic signed [OUT_W-1:0] coef_d;
    logic                    degenerate;
  } cbc_out_t;

endpackage

[hdl/cbc_isqrt.sv]
// Pipelined integer square root, one result bit per stage, with a tag carried along.
module cbc_isqrt #(
  parameter int N_W   = 100,
  parameter int TAG_W = 50
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [N_W-1:0]     in_rad,
  input  logic [TAG_W-1:0]   in_tag,
  output logic               out_valid,
  output logic [N_W/2-1:0]   out_root,
  output logic [TAG_W-1:0]   out_tag
);

  localparam int RT_W = N_W / 2;

  logic             v_r    [0:RT_W];
  logic [N_W-1:0]   rad_r  [0:RT_W];
  logic [RT_W+1:0]  rem_r  [0:RT_W];
  logic [RT_W-1:0]  root_r [0:RT_W];
  logic [TAG_W-1:0] tag_r  [0:RT_W];

  // load the radicand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    rad_r[0]  <= in_rad;
    rem_r[0]  <= '0;
    root_r[0] <= '0;
    tag_r[0]  <= in_tag;
  end

  // one root bit per stage, two radicand bits brought down
  for (genvar s = 1; s <= RT_W; s++) begin : g_step
    logic [RT_W+1:0] rem_sh;
    logic [RT_W+1:0] trial;
    logic            ge;
    logic [RT_W+1:0] rem_nxt;
    logic [RT_W-1:0] root_nxt;

    always_comb begin
      rem_sh   = {rem_r[s-1][RT_W-1:0], rad_r[s-1][N_W-2*s+1 -: 2]};
      trial    = {root_r[s-1], 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[s-1][RT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_r[s-1];
      end
      rad_r[s]  <= rad_r[s-1];
      rem_r[s]  <= rem_nxt;
      root_r[s] <= root_nxt;
      tag_r[s]  <= tag_r[s-1];
    end
  end

  assign out_valid = v_r[RT_W];
  assign out_root  = root_r[RT_W];
  assign out_tag   = tag_r[RT_W];

endmodule

[hdl/cbc_div.sv]
// Pipelined restoring divider: saturating quotient of |dot| * 2^FRAC_BITS by |cross|.
module cbc_div #(
  parameter int DOT_W     = 50,
  parameter int D_W       = 50,
  parameter int Q_W       = 31,
  parameter int FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DOT_W-1:0] in_dot,
  input  logic [D_W-1:0]   in_den,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_quo,
  output logic             out_deg
);

  localparam int NUM_W = DOT_W + FRAC_BITS;
  localparam int HI_W  = NUM_W - Q_W;
  localparam int ST    = Q_W + 1;

  logic             v_r   [0:ST];
  logic [NUM_W-1:0] num_r [0:ST];
  logic [D_W-1:0]   den_r [0:ST];
  logic [D_W-1:0]   rem_r [0:ST];
  logic [Q_W-1:0]   quo_r [0:ST];
  logic             sat_r [0:ST];
  logic             deg_r [0:ST];

  logic [HI_W-1:0]  hi;

  // load numerator and divisor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    num_r[0] <= {in_dot, {FRAC_BITS{1'b0}}};
    den_r[0] <= in_den;
    rem_r[0] <= '0;
    quo_r[0] <= '0;
    sat_r[0] <= 1'b0;
    deg_r[0] <= 1'b0;
  end

  // check for quotient overflow and zero divisor
  assign hi = num_r[0][NUM_W-1:Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[1] <= 1'b0;
    end else begin
      v_r[1] <= v_r[0];
    end
    num_r[1] <= num_r[0];
    den_r[1] <= den_r[0];
    rem_r[1] <= D_W'(hi);
    quo_r[1] <= '0;
    sat_r[1] <= (D_W'(hi) >= den_r[0]);
    deg_r[1] <= (den_r[0] == '0);
  end

  // one quotient bit per stage
  for (genvar s = 2; s <= ST; s++) begin : g_step
    logic [D_W:0]   rem_sh;
    logic [D_W:0]   diff;
    logic           ge;
    logic [D_W-1:0] rem_nxt;
    logic [Q_W-1:0] quo_nxt;

    always_comb begin
      rem_sh  = {rem_r[s-1], num_r[s-1][Q_W-s+1]};
      diff    = rem_sh - {1'b0, den_r[s-1]};
      ge      = (rem_sh >= {1'b0, den_r[s-1]});
      rem_nxt = ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
      quo_nxt = {quo_r[s-1][Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_r[s-1];
      end
      num_r[s] <= num_r[s-1];
      den_r[s] <= den_r[s-1];
      rem_r[s] <= rem_nxt;
      quo_r[s] <= quo_nxt;
      sat_r[s] <= sat_r[s-1];
      deg_r[s] <= deg_r[s-1];
    end
  end

  assign out_valid = v_r[ST];
  assign out_quo   = sat_r[ST] ? '1 : quo_r[ST];
  assign out_deg   = deg_r[ST];

endmodule

[hdl/cbc_pair.sv]
// One edge pair: dot and cross products, |cross| by square root, cotangent by division.
module cbc_pair #(
  parameter int FRAC_BITS = cbc_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  cbc_pkg::vec_t              in_a,
  input  cbc_pkg::vec_t              in_b,
  output logic                       out_valid,
  output logic [cbc_pkg::COT_W-1:0]  out_cot,
  output logic                       out_deg
);

  localparam int PW = cbc_pkg::PROD_W;
  localparam int DW = cbc_pkg::DOT_W;
  localparam int CW = cbc_pkg::CM_W;
  localparam int HW = cbc_pkg::HALF_W;
  localparam int SW = cbc_pkg::SQ_W;

  // products: xx yy zz | yz zy | zx xz | xy yx
  logic signed [PW-1:0] prod_nxt [0:8];
  logic signed [PW-1:0] prod_r   [0:8];
  logic                 va_r;

  always_comb begin
    prod_nxt[0] = in_a.x * in_b.x;
    prod_nxt[1] = in_a.y * in_b.y;
    prod_nxt[2] = in_a.z * in_b.z;
    prod_nxt[3] = in_a.y * in_b.z;
    prod_nxt[4] = in_a.z * in_b.y;
    prod_nxt[5] = in_a.z * in_b.x;
    prod_nxt[6] = in_a.x * in_b.z;
    prod_nxt[7] = in_a.x * in_b.y;
    prod_nxt[8] = in_a.y * in_b.x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else begin
      va_r <= in_valid;
    end
    prod_r <= prod_nxt;
  end

  // sum dot product, difference cross components, take magnitudes
  logic signed [PW+1:0] dot_s;
  logic signed [PW:0]   crs [0:2];
  logic [DW-1:0]        dotm_b_nxt;
  logic [CW-1:0]        cm_nxt [0:2];
  logic [DW-1:0]        dotm_b_r;
  logic [CW-1:0]        cm_r   [0:2];
  logic                 vb_r;

  always_comb begin
    dot_s = (PW+2)'(prod_r[0]) + (PW+2)'(prod_r[1]) + (PW+2)'(prod_r[2]);
    dotm_b_nxt = DW'(dot_s[PW+1] ? -dot_s : dot_s);
    for (int i = 0; i < 3; i++) begin
      crs[i]    = (PW+1)'(prod_r[3+2*i]) - (PW+1)'(prod_r[4+2*i]);
      cm_nxt[i] = CW'(crs[i][PW] ? -crs[i] : crs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else begin
      vb_r <= va_r;
    end
    dotm_b_r <= dotm_b_nxt;
    cm_r     <= cm_nxt;
  end

  // square each magnitude as three partial products
  logic [2*HW-1:0] hh_nxt [0:2];
  logic [2*HW-1:0] hl_nxt [0:2];
  logic [2*HW-1:0] ll_nxt [0:2];
  logic [2*HW-1:0] hh_r   [0:2];
  logic [2*HW-1:0] hl_r   [0:2];
  logic [2*HW-1:0] ll_r   [0:2];
  logic [DW-1:0]   dotm_c_r;
  logic            vc_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hh_nxt[i] = cm_r[i][CW-1:HW] * cm_r[i][CW-1:HW];
      hl_nxt[i] = cm_r[i][CW-1:HW] * cm_r[i][HW-1:0];
      ll_nxt[i] = cm_r[i][HW-1:0]  * cm_r[i][HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else begin
      vc_r <= vb_r;
    end
    hh_r     <= hh_nxt;
    hl_r     <= hl_nxt;
    ll_r     <= ll_nxt;
    dotm_c_r <= dotm_b_r;
  end

  // assemble the squares
  logic [SW-1:0] sq_nxt [0:2];
  logic [SW-1:0] sq_r   [0:2];
  logic [DW-1:0] dotm_d_r;
  logic          vd_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_nxt[i] = (SW'(hh_r[i]) << (2*HW)) + (SW'(hl_r[i]) << (HW+1)) + SW'(ll_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else begin
      vd_r <= vc_r;
    end
    sq_r     <= sq_nxt;
    dotm_d_r <= dotm_c_r;
  end

  // sum of squares is the radicand
  logic [SW-1:0] rad_nxt;
  logic [SW-1:0] rad_r;
  logic [DW-1:0] dotm_e_r;
  logic          ve_r;

  assign rad_nxt = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= vd_r;
    end
    rad_r    <= rad_nxt;
    dotm_e_r <= dotm_d_r;
  end

  // |cross| then cotangent
  logic                    sq_v;
  logic [cbc_pkg::R_W-1:0] root;
  logic [DW-1:0]           sq_dot;

  cbc_isqrt #(
    .N_W   (SW),
    .TAG_W (DW)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ve_r),
    .in_rad    (rad_r),
    .in_tag    (dotm_e_r),
    .out_valid (sq_v),
    .out_root  (root),
    .out_tag   (sq_dot)
  );

  cbc_div #(
    .DOT_W     (DW),
    .D_W       (cbc_pkg::R_W),
    .Q_W       (cbc_pkg::COT_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_dot    (sq_dot),
    .in_den    (root),
    .out_valid (out_valid),
    .out_quo   (out_cot),
    .out_deg   (out_deg)
  );

endmodule

[hdl/cotangent_bending_coefficients_top.sv]
// Top level: edge setup, four cotangent pair pipelines and coefficient sums.
//
//  channel  ports                  handshake
//  input    start, busy, in_data   accepted when start is high and busy is low
//  result   out_valid, out_data    one-cycle strobe, no back-pressure
//
// A transaction can enter every cycle while busy is low; busy is high only during reset.
// The path runs through the edge register, the pair front end, the bit-per-stage square root
// (51 stages), the divider (33 stages) and the output register.
// Reset is synchronous and clears all valid bits; no clearing pass is needed.
// Results cannot be stalled, so the pipeline never holds.
module cotangent_bending_coefficients_top #(
  parameter int FRAC_BITS = cbc_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cbc_pkg::cbc_in_t  in_data,
  output logic              out_valid,
  output cbc_pkg::cbc_out_t out_data
);

  `include "cotangent_bending_coefficients_top_assert.svh"

  localparam int EW  = cbc_pkg::E_W;
  localparam int CTW = cbc_pkg::COT_W;
  localparam int OW  = cbc_pkg::OUT_W;
  localparam int LAT = 2 + cbc_pkg::FRONT_LAT + (cbc_pkg::R_W + 1) + (CTW + 2);

  localparam logic [OW-1:0] POS_MAX = OW'(cbc_pkg::COT_MAX);
  localparam logic [OW-1:0] NEG_MIN = {1'b1, {(OW-1){1'b0}}};

  function automatic logic [OW-1:0] sat_pos(input logic [OW-1:0] s);
    return s[OW-1] ? POS_MAX : s;
  endfunction

  function automatic logic [OW-1:0] sat_neg(input logic [OW-1:0] s);
    return s[OW-1] ? NEG_MIN : (OW'(0) - s);
  endfunction

  logic accept;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // form the edges p0-p1, p0-p2, p0-p3, p1-p2 and p1-p3
  cbc_pkg::vec_t edg_nxt [0:4];
  cbc_pkg::vec_t edg_r   [0:4];
  logic          ve_r;

  always_comb begin
    edg_nxt[0].x = EW'(in_data.p0_x) - EW'(in_data.p1_x);
    edg_nxt[0].y = EW'(in_data.p0_y) - EW'(in_data.p1_y);
    edg_nxt[0].z = EW'(in_data.p0_z) - EW'(in_data.p1_z);
    edg_nxt[1].x = EW'(in_data.p0_x) - EW'(in_data.p2_x);
    edg_nxt[1].y = EW'(in_data.p0_y) - EW'(in_data.p2_y);
    edg_nxt[1].z = EW'(in_data.p0_z) - EW'(in_data.p2_z);
    edg_nxt[2].x = EW'(in_data.p0_x) - EW'(in_data.p3_x);
    edg_nxt[2].y = EW'(in_data.p0_y) - EW'(in_data.p3_y);
    edg_nxt[2].z = EW'(in_data.p0_z) - EW'(in_data.p3_z);
    edg_nxt[3].x = EW'(in_data.p1_x) - EW'(in_data.p2_x);
    edg_nxt[3].y = EW'(in_data.p1_y) - EW'(in_data.p2_y);
    edg_nxt[3].z = EW'(in_data.p1_z) - EW'(in_data.p2_z);
    edg_nxt[4].x = EW'(in_data.p1_x) - EW'(in_data.p3_x);
    edg_nxt[4].y = EW'(in_data.p1_y) - EW'(in_data.p3_y);
    edg_nxt[4].z = EW'(in_data.p1_z) - EW'(in_data.p3_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else begin
      ve_r <= accept;
    end
    edg_r <= edg_nxt;
  end

  // shared edge against each of the other four
  logic [3:0]     pv;
  logic [CTW-1:0] cot [0:3];
  logic [3:0]     pdeg;

  for (genvar k = 0; k < 4; k++) begin : g_pair
    cbc_pair #(
      .FRAC_BITS (FRAC_BITS)
    ) u_pair (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (ve_r),
      .in_a      (edg_r[0]),
      .in_b      (edg_r[k+1]),
      .out_valid (pv[k]),
      .out_cot   (cot[k]),
      .out_deg   (pdeg[k])
    );
  end

  // combine cotangents and saturate
  cbc_pkg::cbc_out_t out_nxt;
  cbc_pkg::cbc_out_t out_data_r;
  logic              out_valid_r;

  always_comb begin
    out_nxt.coef_a     = sat_pos(OW'(cot[2]) + OW'(cot[3]));
    out_nxt.coef_b     = sat_pos(OW'(cot[0]) + OW'(cot[1]));
    out_nxt.coef_c     = sat_neg(OW'(cot[0]) + OW'(cot[2]));
    out_nxt.coef_d     = sat_neg(OW'(cot[1]) + OW'(cot[3]));
    out_nxt.degenerate = |pdeg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= &pv;
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result strobe follows each accepted transaction by the fixed latency
  `CBC_ASSERT_ALWAYS(a_latency, clk, rst_n, out_valid == $past(accept, LAT))
  // a degenerate pair saturates at least one positive coefficient
  `CBC_ASSERT_IMPL(a_deg_sat, clk, rst_n, out_valid && out_data.degenerate, out_data.coef_a == POS_MAX || out_data.coef_b == POS_MAX)
  // sums of cotangents keep their sign
  `CBC_ASSERT_IMPL(a_signs, clk, rst_n, out_valid, !out_data.coef_a[OW-1] && !out_data.coef_b[OW-1] && (out_data.coef_c[OW-1] || out_data.coef_c == '0) && (out_data.coef_d[OW-1] || out_data.coef_d == '0))

endmodule

[tb/testbench.sv]
// Self-checking testbench for the cotangent bending coefficient block.
`timescale 1ns / 100ps

module testbench;

  typedef longint edge3_t [3];

  typedef struct {
    cbc_pkg::cbc_in_t  pts;
    bit                typed;
    cbc_pkg::cbc_out_t coefs;
  } stencil_row_t;

  localparam int FB = cbc_pkg::FRAC_BITS_DEF;
  localparam logic [31:0] POS_SAT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_SAT = 32'h8000_0000;
  localparam int ONE = 1 << FB;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cbc_pkg::cbc_in_t  in_data = '0;
  logic              out_valid;
  cbc_pkg::cbc_out_t out_data;

  cbc_pkg::cbc_out_t coef_pending = '0;
  cbc_pkg::cbc_out_t coef_queue[$];
  int                accepted = 0;
  int                checked = 0;
  int                mismatches = 0;
  int                degen_seen = 0;
  int                idle_pct = 0;
  bit                done = 1'b0;

  cotangent_bending_coefficients_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Cotangent of one edge pair in Q.FB; flags a zero cross product.
  function automatic logic [31:0] pair_cotangent(edge3_t a, edge3_t b, ref bit degen);
    longint dot, cx, cy, cz;
    logic [127:0] sq, num, root, cand;
    dot = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    cx = a[1] * b[2] - a[2] * b[1];
    cy = a[2] * b[0] - a[0] * b[2];
    cz = a[0] * b[1] - a[1] * b[0];
    if (cx < 0) cx = -cx;
    if (cy < 0) cy = -cy;
    if (cz < 0) cz = -cz;
    if (dot < 0) dot = -dot;
    sq = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
    // Floor square root, one bit at a time.
    root = '0;
    for (int i = 51; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= sq) root = cand;
    end
    if (root == 0) begin
      degen = 1'b1;
      return POS_SAT;
    end
    num = 128'(dot) << FB;
    if ((root << 31) <= num) return POS_SAT;
    return 32'(num / root);
  endfunction

  function automatic logic [31:0] clamp_pos(logic [32:0] s);
    return (s > 33'(POS_SAT)) ? POS_SAT : s[31:0];
  endfunction

  function automatic logic [31:0] clamp_neg(logic [32:0] s);
    return (s >= 33'(NEG_SAT)) ? NEG_SAT : 32'(-s);
  endfunction

  function automatic cbc_pkg::cbc_out_t bending_coefs(cbc_pkg::cbc_in_t p);
    edge3_t e0, e1, e2, e3, e4;
    logic [31:0] c1, c2, c3, c4;
    bit degen;
    cbc_pkg::cbc_out_t r;
    longint q0[3], q1[3], q2[3], q3[3];
    q0 = '{longint'(p.p0_x), longint'(p.p0_y), longint'(p.p0_z)};
    q1 = '{longint'(p.p1_x), longint'(p.p1_y), longint'(p.p1_z)};
    q2 = '{longint'(p.p2_x), longint'(p.p2_y), longint'(p.p2_z)};
    q3 = '{longint'(p.p3_x), longint'(p.p3_y), longint'(p.p3_z)};
    for (int k = 0; k < 3; k++) begin
      e0[k] = q0[k] - q1[k];
      e1[k] = q0[k] - q2[k];
      e2[k] = q0[k] - q3[k];
      e3[k] = q1[k] - q2[k];
      e4[k] = q1[k] - q3[k];
    end
    degen = 1'b0;
    c1 = pair_cotangent(e0, e1, degen);
    c2 = pair_cotangent(e0, e2, degen);
    c3 = pair_cotangent(e0, e3, degen);
    c4 = pair_cotangent(e0, e4, degen);
    r.coef_a = clamp_pos(33'(c3) + 33'(c4));
    r.coef_b = clamp_pos(33'(c1) + 33'(c2));
    r.coef_c = clamp_neg(33'(c1) + 33'(c3));
    r.coef_d = clamp_neg(33'(c2) + 33'(c4));
    r.degenerate = degen;
    return r;
  endfunction

  function automatic cbc_pkg::cbc_in_t make_pts(int ax, int ay, int az, int bx, int by, int bz,
                                               int cx, int cy, int cz, int dx, int dy, int dz);
    cbc_pkg::cbc_in_t p;
    p = '{24'(ax), 24'(ay), 24'(az), 24'(bx), 24'(by), 24'(bz),
          24'(cx), 24'(cy), 24'(cz), 24'(dx), 24'(dy), 24'(dz)};
    return p;
  endfunction

  function automatic stencil_row_t make_row(cbc_pkg::cbc_in_t p, bit typed,
                                            cbc_pkg::cbc_out_t coefs);
    stencil_row_t r;
    r.pts   = p;
    r.typed = typed;
    r.coefs = coefs;
    return r;
  endfunction

  // Present one transaction and hold it until taken.
  task automatic send_stencil(cbc_pkg::cbc_in_t p, bit typed, cbc_pkg::cbc_out_t coefs);
    int taken;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_data      <= p;
    coef_pending <= typed ? coefs : bending_coefs(p);
    taken = accepted;
    @(negedge clk);
    while (accepted == taken) @(negedge clk);
  endtask

  // Random stencils: half with points in a random smaller span, some near-collinear, some raw.
  function automatic cbc_pkg::cbc_in_t random_stencil();
    cbc_pkg::cbc_in_t p;
    int sel, span, t;
    sel = $urandom_range(9);
    if (sel < 2) begin
      p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
    end else begin
      span = (sel < 7) ? (1 << $urandom_range(20, 4)) : (1 << 18);
      p = make_pts($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                   $urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
      if (sel >= 7) begin
        // Pull p2 onto the shared edge line, with a little noise.
        t = $urandom_range(4) - 2;
        p.p2_x = p.p0_x + t * (p.p1_x - p.p0_x) + 24'($urandom_range(2) - 1);
        p.p2_y = p.p0_y + t * (p.p1_y - p.p0_y);
        p.p2_z = p.p0_z + t * (p.p1_z - p.p0_z);
      end
    end
    return p;
  endfunction

  // Record accepted transactions and check results against the oldest expectation.
  always @(posedge clk) begin
    cbc_pkg::cbc_out_t want;
    if (start && !busy) begin
      coef_queue.insert(coef_queue.size(), coef_pending);
      accepted <= accepted + 1;
    end
    if (out_valid) begin
      if (coef_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %p", out_data);
      end else begin
        want = coef_queue.pop_front();
        checked++;
        if (out_data.degenerate) degen_seen++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch #%0d: exp a=%h b=%h c=%h d=%h deg=%b, ",
                      "got a=%h b=%h c=%h d=%h deg=%b"},
                     checked, want.coef_a, want.coef_b, want.coef_c, want.coef_d,
                     want.degenerate, out_data.coef_a, out_data.coef_b, out_data.coef_c,
                     out_data.coef_d, out_data.degenerate);
        end
      end
    end
  end

  initial begin
    stencil_row_t rows[$];
    cbc_pkg::cbc_out_t all_sat, none;
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    all_sat = '{POS_SAT, POS_SAT, NEG_SAT, NEG_SAT, 1'b1};
    none = '0;
    // All points equal: every pair degenerate, every sum saturates.
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0),
                                      1'b1, all_sat));
    rows.insert(rows.size(), make_row(make_pts(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx),
                                      1'b1, all_sat));
    rows.insert(rows.size(), make_row(make_pts(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn),
                                      1'b1, all_sat));
    // Extreme spread and well-formed shapes.
    rows.insert(rows.size(), make_row(make_pts(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(mn, mx, mn, mx, mn, mx, mn, mn, mx, mx, mx, mn),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(mx, 0, 0, mn, 0, 0, 0, mx, 0, 0, 0, mn),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, ONE, 0, 0, ONE / 2, ONE, 0,
                                               ONE / 2, -ONE, 0), 1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 1),
                                      1'b0, none));
    // Collinear pairs and a zero-length shared edge.
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, ONE, 0, 0, 2 * ONE, 0, 0, 0, ONE, 0),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(5, 6, 7, 5, 6, 7, 1, 2, 3, 9, 8, 7),
                                      1'b1, all_sat));
    // Very large cotangent: far point almost on the edge line.
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, mx, 0, 0, mn, 1, 0, mx / 2, 0, 1),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(0, 0, 0, mx, mx, 0, mn, mn + 1, 0, 1, 1, 1),
                                      1'b0, none));
    rows.insert(rows.size(), make_row(make_pts(mx, mn, 0, mn, mx, 0, 0, 0, mx, 0, 0, mn),
                                      1'b0, none));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[i]) send_stencil(rows[i].pts, rows[i].typed, rows[i].coefs);

    for (int n = 0; n < 2000; n++) begin
      idle_pct = (n < 700) ? 8 : (n < 1400) ? 46 : 0;
      send_stencil(random_stencil(), 1'b0, none);
    end
    start <= 1'b0;

    // Drain the pipeline, then allow its latency again for stray results.
    while (coef_queue.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
    done = 1'b1;

    $display("Checked %0d coefficient sets (%0d degenerate) over directed extremes,",
             checked, degen_seen);
    $display("random meshes and near-collinear stencils at three sender idle rates.");
    if (mismatches == 0 && coef_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard.
  initial begin
    #5ms;
    if (!done) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
